@@ sv/assert_macros.svh @@
// Assertion macros used by the allocator datapath RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

@@ sv/scsa_pkg.sv @@
// Package for the size class slot allocator: sizes, codes, control structs.
// No dependencies.
package scsa_pkg;

    localparam int MAX_SLOTS   = 64;
    localparam int CLASS_COUNT = 3;
    localparam int DEPTH       = CLASS_COUNT * MAX_SLOTS;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int SLOT_W      = 6;
    localparam int CLS_W       = 2;
    localparam int TOP_W       = 7;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [CLS_W-1:0] {
        REG_SMALL_COUNT  = 2'd0,
        REG_MEDIUM_COUNT = 2'd1,
        REG_LARGE_COUNT  = 2'd2
    } reg_index_t;

    localparam logic [TOP_W-1:0] RESET_COUNT [CLASS_COUNT] = '{7'd10, 7'd50, 7'd10};

    typedef struct packed {
        logic accept;
        logic commit;
    } scsa_cmd_t;

    typedef struct packed {
        logic out_busy;
    } scsa_sts_t;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [CLS_W-1:0] cls,
                                                  input logic [SLOT_W-1:0] slot);
        return ADDR_W'(cls) * ADDR_W'(MAX_SLOTS) + ADDR_W'(slot);
    endfunction

endpackage

@@ sv/scsa_if.sv @@
// Request and result channel interfaces of the allocator.
// Depends on scsa_pkg.
interface scsa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [scsa_pkg::CLS_W-1:0]   size_class;
    logic [scsa_pkg::SLOT_W-1:0]  slot_index;

    modport source (output valid, output operation, output size_class, output slot_index,
                    input ready);
    modport sink (input valid, input operation, input size_class, input slot_index,
                  output ready);
endinterface

interface scsa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [scsa_pkg::CLS_W-1:0]   granted_class;
    logic [scsa_pkg::SLOT_W-1:0]  granted_slot;

    modport source (output valid, output status, output granted_class, output granted_slot,
                    input ready);
    modport sink (input valid, input status, input granted_class, input granted_slot,
                  output ready);
endinterface

@@ sv/scsa_ctrl.sv @@
// Allocator controller: accepts a request, then commits it once the result
// register is free. Depends on scsa_pkg.
module scsa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  scsa_pkg::scsa_sts_t sts,
    output scsa_pkg::scsa_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/scsa_dp.sv @@
// Allocator datapath: free stacks, occupancy, tops, low marks, counts, result register.
// Depends on scsa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scsa_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  scsa_pkg::scsa_cmd_t               cmd,
    output scsa_pkg::scsa_sts_t               sts,
    input  logic                              operation,
    input  logic [scsa_pkg::CLS_W-1:0]        size_class,
    input  logic [scsa_pkg::SLOT_W-1:0]       slot_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [scsa_pkg::CLS_W-1:0]        granted_class,
    output logic [scsa_pkg::SLOT_W-1:0]       granted_slot,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scsa_pkg::PADDR_W-1:0]      paddr,
    input  logic [scsa_pkg::PDATA_W-1:0]      pwdata,
    output logic [scsa_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int CLASS_COUNT = scsa_pkg::CLASS_COUNT;
    localparam int DEPTH       = scsa_pkg::DEPTH;
    localparam int ADDR_W      = scsa_pkg::ADDR_W;
    localparam int SLOT_W      = scsa_pkg::SLOT_W;
    localparam int CLS_W       = scsa_pkg::CLS_W;
    localparam int TOP_W       = scsa_pkg::TOP_W;

    logic [TOP_W-1:0]  count_reg [CLASS_COUNT];
    logic [TOP_W-1:0]  top_reg   [CLASS_COUNT];
    logic [TOP_W-1:0]  low_reg   [CLASS_COUNT];
    logic [SLOT_W-1:0] stk_mem   [DEPTH];
    logic              occ_mem   [DEPTH];

    logic              op_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              found_reg;
    logic              free_pre_reg;
    logic [SLOT_W-1:0] stk_rd_reg;
    logic              occ_rd_reg;
    logic              rd_vld_reg;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [CLS_W-1:0]  gcls_reg;
    logic [SLOT_W-1:0] gslot_reg;

    logic              found;
    logic [CLS_W-1:0]  found_cls;
    logic [TOP_W-1:0]  found_top;
    logic [CLS_W-1:0]  rd_cls;
    logic [SLOT_W-1:0] rd_slot;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_vld;
    logic              free_pre;
    logic              cls_ok;
    logic [TOP_W-1:0]  req_top;
    logic [TOP_W-1:0]  req_count;

    logic [SLOT_W-1:0] pop_slot;
    logic              free_ok;
    logic [TOP_W-1:0]  cur_top;
    logic [TOP_W-1:0]  pop_top;
    logic [ADDR_W-1:0] occ_addr;
    logic [ADDR_W-1:0] push_addr;

    logic              cfg_write;
    logic [CLS_W-1:0]  cfg_idx;
    logic [TOP_W-1:0]  cfg_sat;
    logic              tops_ok;
    logic              lows_ok;

    always_comb
    begin
        found     = 1'b0;
        found_cls = '0;
        found_top = '0;
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            if (!found && CLS_W'(c) >= size_class && top_reg[c] != '0)
            begin
                found     = 1'b1;
                found_cls = CLS_W'(c);
                found_top = top_reg[c];
            end
        end
    end

    always_comb
    begin
        cls_ok    = size_class < CLS_W'(CLASS_COUNT);
        req_top   = cls_ok ? top_reg[size_class] : '0;
        req_count = cls_ok ? count_reg[size_class] : '0;
        free_pre  = cls_ok && (TOP_W'(slot_index) < req_count) &&
                    (req_top < TOP_W'(scsa_pkg::MAX_SLOTS));
        if (operation == scsa_pkg::OP_ALLOC)
        begin
            rd_cls  = found ? found_cls : '0;
            rd_slot = found ? SLOT_W'(found_top - TOP_W'(1)) : '0;
        end
        else
        begin
            rd_cls  = cls_ok ? size_class : '0;
            rd_slot = slot_index;
        end
        rd_addr = scsa_pkg::addr_of(rd_cls, rd_slot);
        // entries below the class low mark have never been written since reset or configuration
        rd_vld  = TOP_W'(rd_slot) >= low_reg[rd_cls];
    end

    always_comb
    begin
        pop_slot  = rd_vld_reg ? stk_rd_reg : slot_reg;
        free_ok   = free_pre_reg && rd_vld_reg && occ_rd_reg;
        cur_top   = top_reg[cls_reg];
        pop_top   = cur_top - TOP_W'(1);
        occ_addr  = scsa_pkg::addr_of(cls_reg, (op_reg == scsa_pkg::OP_ALLOC) ? pop_slot
                                                                             : slot_reg);
        push_addr = scsa_pkg::addr_of(cls_reg, SLOT_W'(cur_top));
    end

    always_comb
    begin
        cfg_write = psel && penable && pwrite;
        cfg_idx   = paddr[CLS_W+1:2];
        cfg_sat   = (pwdata[TOP_W-1:0] > TOP_W'(scsa_pkg::MAX_SLOTS)) ?
                    TOP_W'(scsa_pkg::MAX_SLOTS) : pwdata[TOP_W-1:0];
        pready    = 1'b1;
        prdata    = '0;
        if (cfg_idx < CLS_W'(CLASS_COUNT))
        begin
            prdata = scsa_pkg::PDATA_W'(count_reg[cfg_idx]);
        end
    end

    // stack and occupancy storage
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            stk_rd_reg <= stk_mem[rd_addr];
            occ_rd_reg <= occ_mem[rd_addr];
        end
        if (cmd.commit && op_reg == scsa_pkg::OP_FREE && free_ok)
        begin
            stk_mem[push_addr] <= slot_reg;
        end
        if (cmd.commit && (op_reg == scsa_pkg::OP_ALLOC ? found_reg : free_ok))
        begin
            occ_mem[occ_addr] <= (op_reg == scsa_pkg::OP_ALLOC);
        end
    end

    // request payload held through the execute state
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= operation;
            cls_reg      <= rd_cls;
            slot_reg     <= rd_slot;
            found_reg    <= found;
            free_pre_reg <= free_pre;
            rd_vld_reg   <= rd_vld;
        end
        if (cmd.commit)
        begin
            if (op_reg == scsa_pkg::OP_ALLOC)
            begin
                status_reg <= found_reg ? scsa_pkg::ST_OK : scsa_pkg::ST_FULL;
                gcls_reg   <= found_reg ? cls_reg : '0;
                gslot_reg  <= found_reg ? pop_slot : '0;
            end
            else
            begin
                status_reg <= free_ok ? scsa_pkg::ST_OK : scsa_pkg::ST_BAD_FREE;
                gcls_reg   <= '0;
                gslot_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                count_reg[c] <= scsa_pkg::RESET_COUNT[c];
                top_reg[c]   <= scsa_pkg::RESET_COUNT[c];
                low_reg[c]   <= scsa_pkg::RESET_COUNT[c];
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.commit && op_reg == scsa_pkg::OP_ALLOC && found_reg)
            begin
                top_reg[cls_reg] <= pop_top;
                if (pop_top < low_reg[cls_reg])
                begin
                    low_reg[cls_reg] <= pop_top;
                end
            end
            if (cmd.commit && op_reg == scsa_pkg::OP_FREE && free_ok)
            begin
                top_reg[cls_reg] <= cur_top + TOP_W'(1);
            end
            if (cfg_write && cfg_idx < CLS_W'(CLASS_COUNT))
            begin
                count_reg[cfg_idx] <= cfg_sat;
                top_reg[cfg_idx]   <= cfg_sat;
                low_reg[cfg_idx]   <= cfg_sat;
            end
        end
    end

    assign sts.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_class = gcls_reg;
    assign granted_slot  = gslot_reg;

    always_comb
    begin
        tops_ok = 1'b1;
        lows_ok = 1'b1;
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            if (top_reg[c] > count_reg[c] || count_reg[c] > TOP_W'(scsa_pkg::MAX_SLOTS))
            begin
                tops_ok = 1'b0;
            end
            if (low_reg[c] > top_reg[c])
            begin
                lows_ok = 1'b0;
            end
        end
    end

    `ASSERT_CLK(a_commit_free_slot, !(cmd.commit && sts.out_busy), "commit over pending result")
    `ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid_reg, "committed result not shown")
    `ASSERT_CLK(a_tops_bounded, tops_ok, "stack top beyond class count")
    `ASSERT_CLK(a_low_below_top, lows_ok, "low mark above stack top")

endmodule

@@ sv/size_class_slot_allocator.sv @@
// Size class slot allocator, top level: controller, datapath, APB config.
// Depends on scsa_pkg, scsa_if, scsa_ctrl and scsa_dp.
// Each request is accepted in the idle state and committed from the execute state.
// No new request is taken until the last one commits (registered stack and occupancy read, then
// write-back and top update); a result held by the sink stalls the next commit.
// Reset: asynchronous; counts, tops and low marks load 10/50/10, memories need no clear.
module size_class_slot_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    scsa_req_if.sink                     req,
    scsa_rsp_if.source                   rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [scsa_pkg::PADDR_W-1:0] paddr,
    input  logic [scsa_pkg::PDATA_W-1:0] pwdata,
    output logic [scsa_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    scsa_pkg::scsa_cmd_t cmd;
    scsa_pkg::scsa_sts_t sts;

    scsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    scsa_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .operation     (req.operation),
        .size_class    (req.size_class),
        .slot_index    (req.slot_index),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .status        (rsp.status),
        .granted_class (rsp.granted_class),
        .granted_slot  (rsp.granted_slot),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

endmodule
